/* src/kcbt_pkg.sv */
// ----------------------------------------------------------------------------
// kcbt_pkg
// Shared types and constants of the keyed circuit-breaker table.
// ----------------------------------------------------------------------------
package kcbt_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int KEY_BITS    = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] CMD_ALLOW  = 2'd0;
    localparam logic [1:0] CMD_RECORD = 2'd1;

    localparam logic [1:0] MODE_CLOSED = 2'd0;
    localparam logic [1:0] MODE_OPEN   = 2'd1;
    localparam logic [1:0] MODE_HALF   = 2'd2;

    localparam logic [1:0] REG_FAILURE_LIMIT = 2'd0;
    localparam logic [1:0] REG_SUCCESS_LIMIT = 2'd1;
    localparam logic [1:0] REG_PROBE_CAP     = 2'd2;
    localparam logic [1:0] REG_COOLDOWN      = 2'd3;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [1:0]          mode;
        logic [15:0]         fail_run;
        logic [15:0]         probe_wins;
        logic [15:0]         probes_out;
        logic [63:0]         opened_time;
        logic [63:0]         touched_time;
    } entry_t;

    typedef struct packed {
        logic [15:0] failure_limit;
        logic [15:0] success_limit;
        logic [15:0] probe_cap;
        logic [63:0] cooldown_time;
    } cfg_t;

endpackage

/* src/keyed_circuit_breaker_table.sv */
// ----------------------------------------------------------------------------
// keyed_circuit_breaker_table
// Table of per-key circuit breakers (closed, open, half-open) behind a
// valid/ready request channel and a valid/ready result channel.
//
// Each request transfer carries a command (allow, record, query), a key, a
// success bit and a timestamp, and produces exactly one result transfer.
// The entry table is a register file walked one entry per cycle by a small
// sequencer that shares one key comparator, two 64-bit subtract-and-compares
// for the cooldown and one touched-time comparator.
// A lookup scans the used entries, one per cycle, up to the match or the last
// used entry, then passes through a read state and an update state. An allow
// on a full table with an unknown key adds a second scan of all entries for
// the cooldown check and the oldest closed entry. The block is ready again in
// the cycle after the result transfer and takes no new request before that.
// The result waits in an output register until taken; a stalled receiver
// holds the block. Reset empties the table and restores the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_circuit_breaker_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [63:0]                 cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [63:0]                 s_key_id,
    input  logic                        s_success,
    input  logic [63:0]                 s_now_time,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_allowed,
    output logic [1:0]                  m_breaker_state,
    output logic                        m_tracked,
    output logic [5:0]                  m_key_count
);
    import kcbt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_EVICT = 6'b000100,
        ST_READ  = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    cfg_t   cfg_reg;
    entry_t table_mem [MAX_ENTRIES];

    logic [CNT_W-1:0]    used_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic                found_reg, have_cand_reg, fresh_reg;
    logic [1:0]          cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                ok_reg;
    logic [63:0]         now_reg;
    entry_t              cur_reg;
    logic                out_allowed_reg, out_tracked_reg;
    logic [1:0]          out_mode_reg;

    entry_t              scan_e;
    logic                scan_half;
    logic                last_used, last_all;
    entry_t              upd;
    logic                upd_allowed;
    logic                cur_half;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_allowed = out_allowed_reg;
    assign m_breaker_state = out_mode_reg;
    assign m_tracked = out_tracked_reg;
    assign m_key_count = 6'(used_reg);

    assign scan_e    = table_mem[idx_reg];
    assign scan_half = (scan_e.mode == MODE_OPEN) &&
                       ((now_reg - scan_e.opened_time) >= cfg_reg.cooldown_time);
    assign last_used = ({1'b0, idx_reg} == CNT_W'(used_reg - 1'b1));
    assign last_all  = (idx_reg == IDX_W'(MAX_ENTRIES - 1));
    assign cur_half  = (cur_reg.mode == MODE_OPEN) &&
                       ((now_reg - cur_reg.opened_time) >= cfg_reg.cooldown_time);

    always_comb begin
        upd = cur_reg;
        upd_allowed = 1'b0;
        if (fresh_reg) begin
            upd.key = key_reg;
            upd.mode = MODE_CLOSED;
            upd.fail_run = '0;
            upd.probe_wins = '0;
            upd.probes_out = '0;
            upd.opened_time = '0;
            upd.touched_time = now_reg;
        end
        if (cmd_reg == CMD_RECORD) begin
            upd.touched_time = now_reg;
            if (ok_reg) begin
                if (cur_reg.mode == MODE_HALF) begin
                    if (cur_reg.probe_wins != SAT16) begin
                        upd.probe_wins = cur_reg.probe_wins + 16'd1;
                    end
                    if (cur_reg.probes_out != 16'd0) begin
                        upd.probes_out = cur_reg.probes_out - 16'd1;
                    end
                    if (upd.probe_wins >= cfg_reg.success_limit) begin
                        upd.mode = MODE_CLOSED;
                        upd.fail_run = '0;
                        upd.probe_wins = '0;
                        upd.probes_out = '0;
                    end
                end else if (cur_reg.mode == MODE_CLOSED) begin
                    upd.fail_run = '0;
                end
            end else if (cur_reg.mode == MODE_CLOSED) begin
                if (cur_reg.fail_run != SAT16) begin
                    upd.fail_run = cur_reg.fail_run + 16'd1;
                end
                if (upd.fail_run >= cfg_reg.failure_limit) begin
                    upd.mode = MODE_OPEN;
                    upd.opened_time = now_reg;
                end
            end else if (cur_reg.mode == MODE_HALF) begin
                upd.mode = MODE_OPEN;
                upd.opened_time = now_reg;
                upd.probe_wins = '0;
                upd.probes_out = '0;
            end else begin
                upd.opened_time = now_reg;
            end
        end else if (!fresh_reg) begin
            if (cur_half) begin
                upd.mode = MODE_HALF;
                upd.probes_out = '0;
                upd.probe_wins = '0;
                upd.touched_time = now_reg;
            end
            if (cmd_reg == CMD_ALLOW) begin
                if (upd.mode == MODE_CLOSED) begin
                    upd_allowed = 1'b1;
                end else if (upd.mode == MODE_HALF &&
                             upd.probes_out < cfg_reg.probe_cap) begin
                    upd.probes_out = upd.probes_out + 16'd1;
                    upd.touched_time = now_reg;
                    upd_allowed = 1'b1;
                end
            end
        end else begin
            upd_allowed = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (used_reg == '0) ? ST_READ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_e.key == key_reg) begin
                    state_next = ST_READ;
                end else if (last_used) begin
                    state_next = (cmd_reg == CMD_ALLOW &&
                                  used_reg == CNT_W'(MAX_ENTRIES)) ? ST_EVICT : ST_READ;
                end
            end
            ST_EVICT: begin
                if (last_all) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            cfg_reg.failure_limit <= 16'd5;
            cfg_reg.success_limit <= 16'd1;
            cfg_reg.probe_cap <= 16'd1;
            cfg_reg.cooldown_time <= 64'd30000000000;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_FAILURE_LIMIT: cfg_reg.failure_limit <= cfg_data[15:0];
                    REG_SUCCESS_LIMIT: cfg_reg.success_limit <= cfg_data[15:0];
                    REG_PROBE_CAP:     cfg_reg.probe_cap <= cfg_data[15:0];
                    REG_COOLDOWN:      cfg_reg.cooldown_time <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_READ && !found_reg && cmd_reg == CMD_ALLOW &&
                used_reg != CNT_W'(MAX_ENTRIES)) begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cmd_reg <= s_cmd;
                key_reg <= s_key_id[KEY_BITS-1:0];
                ok_reg <= s_success;
                now_reg <= s_now_time;
                idx_reg <= '0;
                found_reg <= 1'b0;
                have_cand_reg <= 1'b0;
                fresh_reg <= 1'b0;
            end
            ST_SCAN: begin
                if (scan_e.key == key_reg) begin
                    found_reg <= 1'b1;
                    slot_reg <= idx_reg;
                end else if (!last_used) begin
                    idx_reg <= idx_reg + 1'b1;
                end else begin
                    idx_reg <= '0;
                end
            end
            ST_EVICT: begin
                if (scan_half) begin
                    table_mem[idx_reg].mode <= MODE_HALF;
                    table_mem[idx_reg].probes_out <= '0;
                    table_mem[idx_reg].probe_wins <= '0;
                    table_mem[idx_reg].touched_time <= now_reg;
                end else if (scan_e.mode == MODE_CLOSED &&
                             (!have_cand_reg ||
                              scan_e.touched_time < cur_reg.touched_time)) begin
                    have_cand_reg <= 1'b1;
                    slot_reg <= idx_reg;
                    cur_reg.touched_time <= scan_e.touched_time;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            ST_READ: begin
                if (found_reg) begin
                    cur_reg <= table_mem[slot_reg];
                end else if (cmd_reg == CMD_ALLOW) begin
                    if (used_reg != CNT_W'(MAX_ENTRIES)) begin
                        slot_reg <= IDX_W'(used_reg);
                        fresh_reg <= 1'b1;
                        found_reg <= 1'b1;
                    end else if (have_cand_reg) begin
                        fresh_reg <= 1'b1;
                        found_reg <= 1'b1;
                    end
                end
            end
            ST_APPLY: begin
                out_allowed_reg <= (cmd_reg == CMD_ALLOW) && (!found_reg || upd_allowed);
                out_tracked_reg <= found_reg;
                out_mode_reg <= found_reg ? upd.mode : MODE_CLOSED;
                if (found_reg) begin
                    table_mem[slot_reg] <= upd;
                end
            end
            default: ;
        endcase
    end

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn) used_reg <= CNT_W'(MAX_ENTRIES);
    endproperty
    assert property (p_count_bound) else $error("entry count exceeds table size");

    property p_untracked_closed;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_tracked) |-> (m_breaker_state == MODE_CLOSED);
    endproperty
    assert property (p_untracked_closed) else $error("untracked key reports non-closed");

    property p_count_step;
        @(posedge aclk) disable iff (!aresetn)
            (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + 1'b1);
    endproperty
    assert property (p_count_step) else $error("entry count changed by more than one");

    property p_not_ready_busy;
        @(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid);
    endproperty
    assert property (p_not_ready_busy) else $error("ready while result pending");

endmodule

/* bench/tb_keyed_circuit_breaker_table.sv */
// ----------------------------------------------------------------------------
// tb_keyed_circuit_breaker_table
// Self-checking bench for the keyed circuit-breaker table. A directed part
// walks one breaker through closed, open and half-open. Random phases then
// run under several register settings, the extremes among them, and drive a
// small key pool so that the table fills and entries get reused. Each
// accepted request is run through a local breaker model. Every result
// transfer is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_keyed_circuit_breaker_table;
    import kcbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE = 40;

    typedef struct packed {
        logic       allowed;
        logic [1:0] state;
        logic       tracked;
        logic [5:0] count;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_FAILURE_LIMIT;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_ALLOW;
    logic [63:0] s_key_id = '0;
    logic        s_success = 1'b0;
    logic [63:0] s_now_time = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_allowed;
    logic [1:0]  m_breaker_state;
    logic        m_tracked;
    logic [5:0]  m_key_count;

    keyed_circuit_breaker_table DUT (.*);

    always #5 aclk = ~aclk;

    // Local copy of the breaker table.
    logic [15:0] lim_fail, lim_win, lim_probe;
    logic [63:0] cool;
    logic [63:0] brk_key [MAX_ENTRIES];
    logic [1:0]  brk_mode [MAX_ENTRIES];
    logic [15:0] brk_fails [MAX_ENTRIES];
    logic [15:0] brk_wins [MAX_ENTRIES];
    logic [15:0] brk_probes [MAX_ENTRIES];
    logic [63:0] brk_opened [MAX_ENTRIES];
    logic [63:0] brk_touched [MAX_ENTRIES];
    int          brk_used;

    verdict_t    pending_verdicts [$];
    int          errors = 0;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic [63:0] clock_now = 64'd1000;
    logic [63:0] key_pool [POOL_SIZE];

    function automatic int find_entry(logic [63:0] key);
        for (int i = 0; i < brk_used; i++)
            if (brk_key[i] == key) return i;
        return -1;
    endfunction

    function automatic logic [1:0] cool_check(int i, logic [63:0] now);
        if (brk_mode[i] == MODE_OPEN && (now - brk_opened[i]) >= cool) begin
            brk_mode[i] = MODE_HALF;
            brk_probes[i] = 0;
            brk_wins[i] = 0;
            brk_touched[i] = now;
        end
        return brk_mode[i];
    endfunction

    function automatic int claim_entry(logic [63:0] key, logic [63:0] now);
        int slot;
        slot = find_entry(key);
        if (slot >= 0) return slot;
        if (brk_used < MAX_ENTRIES) begin
            slot = brk_used;
            brk_used++;
        end else begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (cool_check(i, now) != MODE_CLOSED) continue;
                if (slot < 0 || brk_touched[i] < brk_touched[slot]) slot = i;
            end
            if (slot < 0) return -1;
        end
        brk_key[slot] = key;
        brk_mode[slot] = MODE_CLOSED;
        brk_fails[slot] = 0;
        brk_wins[slot] = 0;
        brk_probes[slot] = 0;
        brk_opened[slot] = 0;
        brk_touched[slot] = now;
        return slot;
    endfunction

    function automatic void apply_outcome(int i, logic ok, logic [63:0] now);
        brk_touched[i] = now;
        if (ok) begin
            if (brk_mode[i] == MODE_HALF) begin
                if (brk_wins[i] != SAT16) brk_wins[i]++;
                if (brk_probes[i] != 0) brk_probes[i]--;
                if (brk_wins[i] >= lim_win) begin
                    brk_mode[i] = MODE_CLOSED;
                    brk_fails[i] = 0;
                    brk_wins[i] = 0;
                    brk_probes[i] = 0;
                end
            end else if (brk_mode[i] == MODE_CLOSED) begin
                brk_fails[i] = 0;
            end
        end else if (brk_mode[i] == MODE_CLOSED) begin
            if (brk_fails[i] != SAT16) brk_fails[i]++;
            if (brk_fails[i] >= lim_fail) begin
                brk_mode[i] = MODE_OPEN;
                brk_opened[i] = now;
            end
        end else if (brk_mode[i] == MODE_HALF) begin
            brk_mode[i] = MODE_OPEN;
            brk_opened[i] = now;
            brk_wins[i] = 0;
            brk_probes[i] = 0;
        end else begin
            brk_opened[i] = now;
        end
    endfunction

    function automatic verdict_t predict_breaker(logic [1:0] cmd, logic [63:0] key,
                                                 logic ok, logic [63:0] now);
        verdict_t v;
        int slot;
        v = '0;
        if (cmd == CMD_ALLOW) begin
            slot = claim_entry(key, now);
            if (slot < 0) begin
                v.allowed = 1'b1;
            end else begin
                v.tracked = 1'b1;
                v.state = cool_check(slot, now);
                if (v.state == MODE_CLOSED) begin
                    v.allowed = 1'b1;
                end else if (v.state == MODE_HALF && brk_probes[slot] < lim_probe) begin
                    brk_probes[slot]++;
                    brk_touched[slot] = now;
                    v.allowed = 1'b1;
                end
            end
        end else begin
            slot = find_entry(key);
            if (slot >= 0) begin
                v.tracked = 1'b1;
                if (cmd == CMD_RECORD) begin
                    apply_outcome(slot, ok, now);
                    v.state = brk_mode[slot];
                end else begin
                    v.state = cool_check(slot, now);
                end
            end
        end
        v.count = brk_used[5:0];
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(logic [1:0] cmd, logic [63:0] key, logic ok,
                                logic [63:0] now);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_key_id <= key;
        s_success <= ok;
        s_now_time <= now;
        do @(posedge aclk); while (!s_ready);
        pending_verdicts.push_back(predict_breaker(cmd, key, ok, now));
        @(negedge aclk);
    endtask

    task automatic write_register(logic [1:0] index, logic [63:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (index)
            REG_FAILURE_LIMIT: lim_fail = value[15:0];
            REG_SUCCESS_LIMIT: lim_win = value[15:0];
            REG_PROBE_CAP: lim_probe = value[15:0];
            default: cool = value;
        endcase
    endtask

    task automatic load_settings(logic [15:0] f, logic [15:0] w, logic [15:0] p,
                                 logic [63:0] c);
        s_valid <= 1'b0;
        wait (pending_verdicts.size() == 0);
        repeat (80) @(negedge aclk);
        write_register(REG_FAILURE_LIMIT, {$urandom(), 16'($urandom()), f});
        write_register(REG_SUCCESS_LIMIT, {$urandom(), 16'($urandom()), w});
        write_register(REG_PROBE_CAP, {$urandom(), 16'($urandom()), p});
        write_register(REG_COOLDOWN, c);
    endtask

    task automatic test_directed();
        logic [63:0] k;
        k = 64'hA5A5_0000_FFFF_1234;
        load_settings(16'd2, 16'd2, 16'd1, 64'd100);
        send_request(CMD_QUERY, k, 1'b0, 64'd10);
        send_request(CMD_RECORD, k, 1'b0, 64'd11);
        send_request(CMD_ALLOW, k, 1'b0, 64'd12);
        send_request(CMD_RECORD, k, 1'b1, 64'd13);
        send_request(CMD_RECORD, k, 1'b0, 64'd14);
        send_request(CMD_RECORD, k, 1'b0, 64'd15);
        send_request(CMD_ALLOW, k, 1'b1, 64'd50);
        send_request(CMD_RECORD, k, 1'b1, 64'd60);
        send_request(CMD_RECORD, k, 1'b0, 64'd70);
        send_request(CMD_QUERY, k, 1'b0, 64'd169);
        send_request(CMD_SPARE, k, 1'b0, 64'd170);
        send_request(CMD_ALLOW, k, 1'b0, 64'd171);
        send_request(CMD_ALLOW, k, 1'b0, 64'd172);
        send_request(CMD_RECORD, k, 1'b1, 64'd173);
        send_request(CMD_RECORD, k, 1'b0, 64'd174);
        send_request(CMD_ALLOW, k, 1'b0, 64'd300);
        send_request(CMD_RECORD, k, 1'b1, 64'd301);
        send_request(CMD_ALLOW, k, 1'b0, 64'd302);
        send_request(CMD_RECORD, k, 1'b1, 64'd303);
        send_request(CMD_ALLOW, '0, 1'b1, '1);
        send_request(CMD_ALLOW, '1, 1'b1, '1);
        send_request(CMD_RECORD, '1, 1'b0, 64'd5);
        send_request(CMD_ALLOW, '1, 1'b0, 64'd3);
        send_request(CMD_SPARE, '0, 1'b1, '0);
    endtask

    // Most requests come from a small key pool so that the table fills up.
    task automatic test_random_phase(logic [15:0] f, logic [15:0] w, logic [15:0] p,
                                     logic [63:0] c, int count);
        logic [63:0] k;
        logic [1:0] cmd;
        load_settings(f, w, p, c);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 19) == 0) clock_now = {$urandom(), $urandom()};
            else clock_now += $urandom_range(0, 80);
            if ($urandom_range(0, 9) == 0) k = {$urandom(), $urandom()};
            else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            case ($urandom_range(0, 9))
                0, 1, 2, 3: cmd = CMD_ALLOW;
                4, 5, 6, 7: cmd = CMD_RECORD;
                8: cmd = CMD_QUERY;
                default: cmd = CMD_SPARE;
            endcase
            send_request(cmd, k, $urandom_range(0, 2) != 0, clock_now);
        end
    endtask

    always @(negedge aclk)
        m_ready <= aresetn && ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result transfer", $time);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_allowed !== want.allowed) begin
                    $display("%0t: allowed expected %0d actual %0d",
                             $time, want.allowed, m_allowed);
                    errors++;
                end
                if (m_breaker_state !== want.state) begin
                    $display("%0t: breaker_state expected %0d actual %0d",
                             $time, want.state, m_breaker_state);
                    errors++;
                end
                if (m_tracked !== want.tracked) begin
                    $display("%0t: tracked expected %0d actual %0d",
                             $time, want.tracked, m_tracked);
                    errors++;
                end
                if (m_key_count !== want.count) begin
                    $display("%0t: key_count expected %0d actual %0d",
                             $time, want.count, m_key_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        lim_fail = 16'd5;
        lim_win = 16'd1;
        lim_probe = 16'd1;
        cool = 64'd30000000000;
        brk_used = 0;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), $urandom()};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        tx_idle_pct = 34;
        rx_idle_pct = 72;
        test_directed();
        test_random_phase(16'd5, 16'd1, 16'd1, 64'd30000000000, 120);
        test_random_phase(16'd1, 16'd1, 16'd1, 64'd1, 150);
        tx_idle_pct = 72;
        rx_idle_pct = 34;
        test_random_phase(16'd0, 16'd0, 16'd0, 64'd0, 150);
        test_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 130);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_phase(16'd3, 16'd2, 16'd2, 64'd200, 150);
        test_random_phase(16'd1, 16'd3, 16'd1, 64'd60, 150);
        s_valid <= 1'b0;
        wait (pending_verdicts.size() == 0);
        repeat (80) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
src/kcbt_pkg.sv
src/keyed_circuit_breaker_table.sv
bench/tb_keyed_circuit_breaker_table.sv
